// ===== design/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
`timescale 1ns / 1ps
package mcr_pkg;

	localparam int RADIUS_BITS = 14;
	localparam int COORD_W     = 15;
	localparam int SPAN_W      = 16;
	localparam int RAD_W       = 14;
	localparam int XD_W        = 17;
	localparam int YD_W        = 16;
	localparam int ERR_W       = 17;
	localparam int IDX_W       = 3;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Kind of work one step item hands to the back end.
	typedef enum logic [1:0] {
		JOB_DONE,
		JOB_OUTLINE,
		JOB_FILL_FULL,
		JOB_FILL_HALF
	} mcr_kind_t;

	typedef struct packed {
		mcr_kind_t                   kind;
		logic signed [COORD_W-1:0]   x;
		logic signed [COORD_W-1:0]   y;
		logic signed [COORD_W-1:0]   xs;
		logic signed [COORD_W-1:0]   ys;
	} mcr_job_t;

	// Index of the final result that a job produces.
	function automatic logic [IDX_W-1:0] last_idx(input mcr_kind_t kind);
		case (kind)
			JOB_DONE:      last_idx = IDX_W'(0);
			JOB_OUTLINE:   last_idx = IDX_W'(7);
			JOB_FILL_FULL: last_idx = IDX_W'(3);
			JOB_FILL_HALF: last_idx = IDX_W'(1);
			default:       last_idx = IDX_W'(0);
		endcase
	endfunction

endpackage

// ===== design/midpoint_circle_rasterizer_unit.sv =====
// Top level of the midpoint circle rasterizer: front end, job queue, back end.
// Steps pass a queue entry and the job register before the output register.
// Throughput: one result per cycle unless the output is stalled; a step gives 8
//   results (outline), 4 or 2 (filled) or 1 (done); a queued step follows
//   the previous one with no gap. Start items produce no result; the 2-entry
//   queue sets how far the front end runs ahead of the result port.
// Reset: arst_n clears the circle state to idle and empties queue and output.
`timescale 1ns / 1ps
module midpoint_circle_rasterizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // center_x[14:0], center_y[29:15], radius[43:30],
	                              // fill_mode[44], zero pad
	input  logic [0:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // span_start[15:0], span_end[31:16], row[47:32]
	output logic [1:0]  m_tuser,  // has_pixels[0], done_res[1]
	output logic        m_tlast
);
	import mcr_pkg::*;

	mcr_job_t          push_job, pop_job;
	logic              push, pop, q_full, q_empty;
	logic [SPAN_W-1:0] span_start, span_end, row;
	logic              has_pixels, done_res;

	// Front end: decode each item, advance the midpoint terms on a step.
	mcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.command   (s_tuser[0]),
		.center_x  (s_tdata[14:0]),
		.center_y  (s_tdata[29:15]),
		.radius    (s_tdata[43:30]),
		.fill_mode (s_tdata[44]),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	// Decouple: hold up to two pending steps while results drain.
	mcr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// Back end: expand each step into spans behind the output register.
	mcr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (pop_job),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.span_start (span_start),
		.span_end   (span_end),
		.row        (row),
		.has_pixels (has_pixels),
		.done_res   (done_res),
		.last       (m_tlast)
	);

	assign m_tdata = {row, span_end, span_start};
	assign m_tuser = {done_res, has_pixels};

	// The queue never takes a job while full, nor gives one while empty.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("job pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("job popped from empty queue");

	// The done-only result is alone: it carries no pixels and closes its step.
	a_done_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
		else $error("done result not marked last or has pixels");

endmodule

// ===== design/mcr_front.sv =====
// Front end: takes input items, keeps the midpoint terms, issues jobs.
`timescale 1ns / 1ps
module mcr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic [mcr_pkg::COORD_W-1:0] center_x,
	input  logic [mcr_pkg::COORD_W-1:0] center_y,
	input  logic [mcr_pkg::RAD_W-1:0]   radius,
	input  logic                       fill_mode,
	output logic                       push,
	output mcr_pkg::mcr_job_t          push_job,
	input  logic                       q_full
);
	import mcr_pkg::*;

	localparam logic [COORD_W-1:0] RMASK = COORD_W'((1 << RADIUS_BITS) - 1);

	logic signed [COORD_W-1:0] step_x_q, step_y_q, cx_q, cy_q;
	logic signed [XD_W-1:0]    x_delta_q;
	logic signed [YD_W-1:0]    y_delta_q;
	logic signed [ERR_W-1:0]   err_acc_q;
	logic                      fill_q, running_q;

	logic                      accept, finished;
	logic [COORD_W-1:0]        r_m;
	logic signed [ERR_W-1:0]   err_n;
	logic signed [ERR_W+1:0]   decide;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign finished = !running_q || (step_x_q < step_y_q);
	assign push     = accept && (command == CMD_STEP);

	assign r_m    = {1'b0, radius} & RMASK;
	assign err_n  = err_acc_q + {y_delta_q[YD_W-1], y_delta_q};
	assign decide = {err_n[ERR_W-1], err_n, 1'b0} +
	                {{(ERR_W+2-XD_W){x_delta_q[XD_W-1]}}, x_delta_q};

	always_comb begin
		push_job.x  = cx_q;
		push_job.y  = cy_q;
		push_job.xs = step_x_q;
		push_job.ys = step_y_q;
		if (finished) begin
			push_job.kind = JOB_DONE;
		end else if (!fill_q) begin
			push_job.kind = JOB_OUTLINE;
		end else if (step_y_q > 0) begin
			push_job.kind = JOB_FILL_FULL;
		end else begin
			push_job.kind = JOB_FILL_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q  <= '0;
			step_y_q  <= '0;
			x_delta_q <= '0;
			y_delta_q <= '0;
			err_acc_q <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			fill_q    <= 1'b0;
			running_q <= 1'b0;
		end else if (accept) begin
			if (command == CMD_START) begin
				cx_q      <= center_x;
				cy_q      <= center_y;
				fill_q    <= fill_mode;
				step_x_q  <= r_m;
				step_y_q  <= '0;
				x_delta_q <= XD_W'(1) - {1'b0, r_m, 1'b0};
				y_delta_q <= '0;
				err_acc_q <= '0;
				running_q <= 1'b1;
			end else if (finished) begin
				running_q <= 1'b0;
			end else begin
				step_y_q  <= step_y_q + COORD_W'(1);
				y_delta_q <= y_delta_q + YD_W'(2);
				if (!decide[ERR_W+1] && (decide != '0)) begin
					step_x_q  <= step_x_q - COORD_W'(1);
					err_acc_q <= err_n + x_delta_q;
					x_delta_q <= x_delta_q + XD_W'(2);
				end else begin
					err_acc_q <= err_n;
				end
			end
		end
	end

endmodule

// ===== design/mcr_queue.sv =====
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
module mcr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mcr_pkg::mcr_job_t push_job,
	output logic              full,
	input  logic              pop,
	output mcr_pkg::mcr_job_t pop_job,
	output logic              empty
);
	import mcr_pkg::*;

	mcr_job_t   mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/mcr_back.sv =====
// Back end: expands one job into its spans, one result per cycle unless the output is stalled.
`timescale 1ns / 1ps
module mcr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  mcr_pkg::mcr_job_t          q_job,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mcr_pkg::SPAN_W-1:0] span_start,
	output logic [mcr_pkg::SPAN_W-1:0] span_end,
	output logic [mcr_pkg::SPAN_W-1:0] row,
	output logic                       has_pixels,
	output logic                       done_res,
	output logic                       last
);
	import mcr_pkg::*;

	logic                    active_q;
	logic [IDX_W-1:0]        idx_q;
	mcr_kind_t               kind_q;
	logic [SPAN_W-1:0]       xm_xs_q, xp_xs_q, xm_ys_q, xp_ys_q, xp_ys1_q;
	logic [SPAN_W-1:0]       yp_ys_q, ym_ys_q, yp_xs_q, ym_xs_q;
	logic [SPAN_W-1:0]       ex, ey, exs, eys;
	logic                    adv, emit, is_last;
	logic [SPAN_W-1:0]       s_n, e_n, r_n;

	assign ex  = {q_job.x[COORD_W-1], q_job.x};
	assign ey  = {q_job.y[COORD_W-1], q_job.y};
	assign exs = {q_job.xs[COORD_W-1], q_job.xs};
	assign eys = {q_job.ys[COORD_W-1], q_job.ys};

	assign adv     = !out_valid || out_ready;
	assign emit    = active_q && adv;
	assign is_last = idx_q == last_idx(kind_q);
	assign pop     = !q_empty && (!active_q || (emit && is_last));

	always_comb begin
		s_n = '0;
		e_n = '0;
		r_n = '0;
		case (kind_q)
			JOB_OUTLINE: begin
				case (idx_q)
					3'd0:    begin s_n = xm_xs_q; r_n = yp_ys_q; end
					3'd1:    begin s_n = xm_xs_q; r_n = ym_ys_q; end
					3'd2:    begin s_n = xp_xs_q; r_n = ym_ys_q; end
					3'd3:    begin s_n = xp_xs_q; r_n = yp_ys_q; end
					3'd4:    begin s_n = xm_ys_q; r_n = yp_xs_q; end
					3'd5:    begin s_n = xm_ys_q; r_n = ym_xs_q; end
					3'd6:    begin s_n = xp_ys_q; r_n = ym_xs_q; end
					default: begin s_n = xp_ys_q; r_n = yp_xs_q; end
				endcase
				e_n = s_n;
			end
			JOB_FILL_FULL, JOB_FILL_HALF: begin
				case (idx_q)
					3'd0:    begin s_n = xm_xs_q; e_n = xp_xs_q;  r_n = yp_ys_q; end
					3'd1:    begin s_n = xm_xs_q; e_n = xp_xs_q;  r_n = ym_ys_q; end
					3'd2:    begin s_n = xm_ys_q; e_n = xp_ys1_q; r_n = yp_xs_q; end
					default: begin s_n = xm_ys_q; e_n = xp_ys1_q; r_n = ym_xs_q; end
				endcase
			end
			default: begin
				s_n = '0;
			end
		endcase
	end

	// Job register: precompute all corner coordinates when a job is taken.
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= q_job.kind;
			xm_xs_q  <= ex - exs;
			xp_xs_q  <= ex + exs;
			xm_ys_q  <= ex - eys;
			xp_ys_q  <= ex + eys;
			xp_ys1_q <= ex + eys - SPAN_W'(1);
			yp_ys_q  <= ey + eys;
			ym_ys_q  <= ey - eys;
			yp_xs_q  <= ey + exs;
			ym_xs_q  <= ey - exs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (emit) begin
			idx_q <= idx_q + IDX_W'(1);
			if (is_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			span_start <= s_n;
			span_end   <= e_n;
			row        <= r_n;
			has_pixels <= kind_q != JOB_DONE;
			done_res   <= kind_q == JOB_DONE;
			last       <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= active_q;
		end
	end

endmodule
